// ===== hw/rtl/egsr_pkg.sv =====
`timescale 1ns / 1ps

package egsr_pkg;

  localparam int MaxParticles = 4096;
  localparam int IdxW         = 12;
  localparam int CntW         = 13;
  localparam int WeightW      = 16;
  localparam int WsumW        = 28;
  localparam int SqW          = 44;
  localparam int DrawW        = 13;
  localparam int ProdW        = WsumW + DrawW;
  localparam int SqSplit      = SqW / 2;
  localparam int SqPartW      = SqSplit + CntW;
  localparam int SqTotW       = SqW + CntW;
  // Resampling is skipped below 2 * 2^(2 * WeightW) for square_sum * N.
  localparam int SkipLimBit   = 2 * WeightW + 1;

  localparam logic [DrawW-1:0] DrawsReset = DrawW'(1024);
  localparam logic [DrawW-1:0] DrawsMax   = DrawW'(4096);

  // Result of the accumulate stage for one particle.
  typedef struct packed {
    logic [IdxW-1:0]    index;
    logic               ovf;
    logic               first;
    logic               last;
    logic [WeightW-1:0] offset;
    logic [WsumW-1:0]   wsum;
    logic [SqW-1:0]     sqsum;
    logic [CntW-1:0]    count;
  } acc_t;

  // Result of the multiply stage for one particle.
  typedef struct packed {
    logic [IdxW-1:0]    index;
    logic               ovf;
    logic               first;
    logic               last;
    logic [WeightW-1:0] offset;
    logic [ProdW-1:0]   wprod;
    logic [SqPartW-1:0] sq_hi;
    logic [SqPartW-1:0] sq_lo;
    logic               sq_nz;
    logic               enough;
  } prod_t;

  function automatic logic [DrawW-1:0] clamp_draws(input logic [DrawW-1:0] v);
    logic [DrawW-1:0] r;
    if (v == '0) begin
      r = DrawW'(1);
    end else if (v > DrawsMax) begin
      r = DrawsMax;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/egsr_accum.sv =====
`timescale 1ns / 1ps

module egsr_accum import egsr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [WeightW-1:0] weight_i,
  input  logic [WeightW-1:0] offset_i,
  input  logic               first_i,
  input  logic               last_i,
  output logic               valid_o,
  input  logic               ready_i,
  output acc_t               acc_o
);

  logic               in_valid_q;
  logic [WeightW-1:0] in_weight_q;
  logic [WeightW-1:0] in_offset_q;
  logic               in_first_q;
  logic               in_last_q;

  logic               acc_valid_q;
  acc_t               acc_q, acc_d;

  logic [WsumW-1:0]   wsum_q, wsum_d;
  logic [SqW-1:0]     sqsum_q, sqsum_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [WeightW-1:0] held_u_q, held_u_d;

  logic               acc_ready;
  logic               advance;
  logic [WsumW-1:0]   base_wsum;
  logic [SqW-1:0]     base_sq;
  logic [CntW-1:0]    base_count;
  logic [WsumW:0]     wsum_sum;
  logic [2*WeightW-1:0] wsq;
  logic [SqW:0]       sq_sum;
  logic               ovf;

  assign acc_ready = !acc_valid_q || ready_i;
  assign ready_o   = !in_valid_q || acc_ready;
  assign advance   = in_valid_q && acc_ready;
  assign valid_o   = acc_valid_q;
  assign acc_o     = acc_q;

  always_comb begin
    base_wsum  = in_first_q ? '0 : wsum_q;
    base_sq    = in_first_q ? '0 : sqsum_q;
    base_count = in_first_q ? '0 : count_q;
    held_u_d   = in_first_q ? in_offset_q : held_u_q;

    ovf = base_count >= CntW'(MaxParticles);
    if (ovf) begin
      count_d = CntW'(MaxParticles);
    end else begin
      count_d = base_count + CntW'(1);
    end

    wsum_sum = {1'b0, base_wsum} + (WsumW + 1)'(in_weight_q);
    wsum_d   = wsum_sum[WsumW] ? '1 : wsum_sum[WsumW-1:0];

    wsq     = (2 * WeightW)'(in_weight_q) * (2 * WeightW)'(in_weight_q);
    sq_sum  = {1'b0, base_sq} + (SqW + 1)'(wsq);
    sqsum_d = sq_sum[SqW] ? '1 : sq_sum[SqW-1:0];

    acc_d.index  = ovf ? IdxW'(MaxParticles - 1) : base_count[IdxW-1:0];
    acc_d.ovf    = ovf;
    acc_d.first  = in_first_q;
    acc_d.last   = in_last_q;
    acc_d.offset = held_u_d;
    acc_d.wsum   = wsum_d;
    acc_d.sqsum  = sqsum_d;
    acc_d.count  = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      acc_valid_q <= 1'b0;
      wsum_q      <= '0;
      sqsum_q     <= '0;
      count_q     <= '0;
      held_u_q    <= '0;
    end else begin
      if (ready_o) begin
        in_valid_q <= valid_i;
      end
      if (acc_ready) begin
        acc_valid_q <= in_valid_q;
      end
      if (advance) begin
        held_u_q <= held_u_d;
        // The last particle closes the set; the held offset survives.
        if (in_last_q) begin
          wsum_q  <= '0;
          sqsum_q <= '0;
          count_q <= '0;
        end else begin
          wsum_q  <= wsum_d;
          sqsum_q <= sqsum_d;
          count_q <= count_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      in_weight_q <= weight_i;
      in_offset_q <= offset_i;
      in_first_q  <= first_i;
      in_last_q   <= last_i;
    end
    if (advance) begin
      acc_q <= acc_d;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxParticles))
    else $error("particle count beyond its saturation value");

  a_ovf_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_valid_q && acc_q.ovf |-> acc_q.index == IdxW'(MaxParticles - 1))
    else $error("overflowing particle without saturated index");
`endif

endmodule

// ===== hw/rtl/egsr_mult.sv =====
`timescale 1ns / 1ps

module egsr_mult import egsr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [DrawW-1:0] draw_count_i,
  input  logic             valid_i,
  output logic             ready_o,
  input  acc_t             acc_i,
  output logic             valid_o,
  input  logic             ready_i,
  output prod_t            prod_o
);

  logic  prod_valid_q;
  prod_t prod_q, prod_d;

  assign ready_o = !prod_valid_q || ready_i;
  assign valid_o = prod_valid_q;
  assign prod_o  = prod_q;

  // Three independent products: the scaled weight sum, and the sum of squares
  // times N split in two halves to keep each multiplier narrow.
  always_comb begin
    prod_d.index  = acc_i.index;
    prod_d.ovf    = acc_i.ovf;
    prod_d.first  = acc_i.first;
    prod_d.last   = acc_i.last;
    prod_d.offset = acc_i.offset;
    prod_d.wprod  = ProdW'(acc_i.wsum) * ProdW'(draw_count_i);
    prod_d.sq_hi  = SqPartW'(acc_i.sqsum[SqW-1:SqSplit]) * SqPartW'(acc_i.count);
    prod_d.sq_lo  = SqPartW'(acc_i.sqsum[SqSplit-1:0]) * SqPartW'(acc_i.count);
    prod_d.sq_nz  = |acc_i.sqsum;
    prod_d.enough = acc_i.count >= draw_count_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else if (ready_o) begin
      prod_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      prod_q <= prod_d;
    end
  end

endmodule

// ===== hw/rtl/egsr_draw.sv =====
`timescale 1ns / 1ps

module egsr_draw import egsr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [DrawW-1:0] draw_count_i,
  input  logic             valid_i,
  output logic             ready_o,
  input  prod_t            prod_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [IdxW-1:0]  index_o,
  output logic [DrawW-1:0] copies_o,
  output logic             final_o,
  output logic             need_o,
  output logic             ovf_o
);

  logic             out_valid_q;
  logic [IdxW-1:0]  index_q;
  logic [DrawW-1:0] copies_q, copies_d;
  logic             final_q;
  logic             need_q, need_d;
  logic             ovf_q;
  logic [DrawW-1:0] taken_q, taken_d;

  logic             advance;
  logic [DrawW-1:0] taken_base;
  logic [ProdW-1:0] diff;
  logic [ProdW-WeightW:0] steps;
  logic [DrawW-1:0] cum;
  logic [SqTotW:0]  sq_total;
  logic             sq_small;

  assign ready_o = !out_valid_q || out_ready_i;
  assign advance = valid_i && ready_o;

  always_comb begin
    taken_base = prod_i.first ? '0 : taken_q;

    // Draws at or below the running sum: none before the first point,
    // otherwise one plus the whole steps past it, capped at D.
    diff  = prod_i.wprod - ProdW'(prod_i.offset);
    steps = (ProdW - WeightW + 1)'(diff[ProdW-1:WeightW]) + (ProdW - WeightW + 1)'(1);
    if (prod_i.wprod < ProdW'(prod_i.offset)) begin
      cum = '0;
    end else if (steps > (ProdW - WeightW + 1)'(draw_count_i)) begin
      cum = draw_count_i;
    end else begin
      cum = steps[DrawW-1:0];
    end

    sq_total = (SqTotW + 1)'({prod_i.sq_hi, {SqSplit{1'b0}}})
             + (SqTotW + 1)'(prod_i.sq_lo);
    sq_small = sq_total < ((SqTotW + 1)'(1) << SkipLimBit);

    if (prod_i.last) begin
      copies_d = (draw_count_i > taken_base) ? draw_count_i - taken_base : '0;
      taken_d  = '0;
      need_d   = !(prod_i.sq_nz && sq_small && prod_i.enough);
    end else begin
      need_d = 1'b0;
      if (cum > taken_base) begin
        copies_d = cum - taken_base;
        taken_d  = cum;
      end else begin
        copies_d = '0;
        taken_d  = taken_base;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      taken_q     <= '0;
    end else begin
      if (ready_o) begin
        out_valid_q <= valid_i;
      end
      if (advance) begin
        taken_q <= taken_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      index_q  <= prod_i.index;
      copies_q <= copies_d;
      final_q  <= prod_i.last;
      need_q   <= need_d;
      ovf_q    <= prod_i.ovf;
    end
  end

  assign out_valid_o = out_valid_q;
  assign index_o     = index_q;
  assign copies_o    = copies_q;
  assign final_o     = final_q;
  assign need_o      = need_q;
  assign ovf_o       = ovf_q;

`ifndef SYNTH
  a_need_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !final_q |-> !need_q)
    else $error("resample flag raised on a particle that is not the last");

  a_taken_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && prod_i.last |=> taken_q == '0)
    else $error("draw count not cleared after the last particle");

  a_copies_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> copies_q <= DrawsMax)
    else $error("copy count beyond the largest draw count");
`endif

endmodule

// ===== hw/rtl/ess_gated_systematic_resampler.sv =====
`timescale 1ns / 1ps

// Streaming systematic resampler with an effective-sample-size gate. Each
// request on the slave side carries one normalized Q0.16 particle weight; the
// first particle of a set (tuser high) also carries the random draw offset u.
// Each request produces exactly one result: the particle index and the number
// of copies it gets among D draws, where D is the configuration register
// (0 acts as 1, values above 4096 act as 4096). The last particle (tlast)
// takes every remaining draw and also reports whether resampling is needed.
// The block takes one request per clock while the output is not stalled. A
// request accepted into the input register passes through the weight and
// square accumulation, the three multiplies of the sums by D and N, and the
// draw count update in the output register, which returns its result. A
// stalled output only holds back the stages behind it once they are full.
// Write the register only while no request is in flight.

module ess_gated_systematic_resampler import egsr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,     // desired_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,    // [15:0] weight, [31:16] offset
  input  logic        s_axis_tuser,    // [0] first
  input  logic        s_axis_tlast,    // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,    // [11:0] index, [24:12] copies, [31:25] zero
  output logic [1:0]  m_axis_tuser,    // [0] resample_needed, [1] overflow
  output logic        m_axis_tlast     // final_res
);

  logic [DrawW-1:0] desired_q;
  logic [DrawW-1:0] draw_count;

  logic  acc_valid, acc_ready;
  acc_t  acc;
  logic  prod_valid, prod_ready;
  prod_t prod;

  logic [IdxW-1:0]  index;
  logic [DrawW-1:0] copies;
  logic             need;
  logic             ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desired_q <= DrawsReset;
    end else if (cfg_we_i) begin
      desired_q <= cfg_wdata_i;
    end
  end

  assign draw_count = clamp_draws(desired_q);

  egsr_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .weight_i (s_axis_tdata[15:0]),
    .offset_i (s_axis_tdata[31:16]),
    .first_i  (s_axis_tuser),
    .last_i   (s_axis_tlast),
    .valid_o  (acc_valid),
    .ready_i  (acc_ready),
    .acc_o    (acc)
  );

  egsr_mult u_mult (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .draw_count_i (draw_count),
    .valid_i      (acc_valid),
    .ready_o      (acc_ready),
    .acc_i        (acc),
    .valid_o      (prod_valid),
    .ready_i      (prod_ready),
    .prod_o       (prod)
  );

  egsr_draw u_draw (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .draw_count_i (draw_count),
    .valid_i      (prod_valid),
    .ready_o      (prod_ready),
    .prod_i       (prod),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .index_o      (index),
    .copies_o     (copies),
    .final_o      (m_axis_tlast),
    .need_o       (need),
    .ovf_o        (ovf)
  );

  assign m_axis_tdata = {7'd0, copies, index};
  assign m_axis_tuser = {ovf, need};

endmodule
